// File: rtl/harmonic_contact_pair_hessian_assert.svh
// Assertion macros for the contact pair Hessian block.
// Needs clk and rst_n in the scope that uses them.
`ifndef HARMONIC_CONTACT_PAIR_HESSIAN_ASSERT_SVH
`define HARMONIC_CONTACT_PAIR_HESSIAN_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HCPH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcph assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HCPH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcph assertion failed");

`endif

// File: rtl/hcph_pkg.sv
// Shared widths, register indexes and reset values for the contact pair Hessian.
// No dependencies.
package hcph_pkg;
  localparam int POS_W     = 32;
  localparam int CELL_W    = 8;
  localparam int CELLS_W   = 9;
  localparam int RAD_W     = 24;
  localparam int HESS_W    = 48;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BOX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd2;

  localparam logic [POS_W-1:0]   BOX_RST   = 32'd1048576;
  localparam logic [CELLS_W-1:0] CELLS_RST = 9'd16;
  localparam int MAX_CELLS_DEF = 256;

  // Datapath widths
  localparam int SUM_W  = 25;  // radius sum
  localparam int MAG_W  = 33;  // |dx|, |dy|
  localparam int SQ_W   = 66;  // squares and cross product
  localparam int Q_W    = 67;  // squared distance
  localparam int ROOT_W = 34;  // integer square root
  localparam int S2_W   = 50;  // squared radius sum
  localparam int SR_W   = 59;  // radius sum times distance
  localparam int INV_W  = 65;  // reciprocal quotients

  // Divider defaults: 2^64 over a 59-bit divisor
  localparam int DIV_NW = 66;
  localparam int DIV_DW = 59;
  localparam int DIV_QW = 65;
endpackage

// File: rtl/hcph_div.sv
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// Uses hcph_pkg for default widths. Quotient must fit in QW bits.
module hcph_div #(
  parameter int NW = hcph_pkg::DIV_NW,
  parameter int DW = hcph_pkg::DIV_DW,
  parameter int QW = hcph_pkg::DIV_QW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] nl_r  [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_i;
    logic [QW-1:0] nl_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] quo_i;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_i = DW'(num[NW-1:QW]);
      assign nl_i  = num[QW-1:0];
      assign den_i = den;
      assign quo_i = '0;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign nl_i  = nl_r[k-1];
      assign den_i = den_r[k-1];
      assign quo_i = quo_r[k-1];
    end

    assign trial = {rem_i, nl_i[QW-1]};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
        nl_r[k]  <= {nl_i[QW-2:0], 1'b0};
        den_r[k] <= den_i;
        quo_r[k] <= {quo_i[QW-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QW-1];
endmodule

// File: rtl/harmonic_contact_pair_hessian.sv
// Cross block of the harmonic soft-disk contact Hessian for one disk pair per
// cycle while the skid entry is empty. The datapath is 106 register stages deep.
// The depth is set by the 34-step square root and the 65-step reciprocal
// dividers, all fully pipelined. Coincident centres give zero entries with
// tuser set.
// Depends on hcph_pkg, hcph_div and harmonic_contact_pair_hessian_assert.svh.
`include "harmonic_contact_pair_hessian_assert.svh"
module harmonic_contact_pair_hessian #(
  parameter int MAX_CELLS = hcph_pkg::MAX_CELLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hcph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hcph_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // x_a, y_a, x_b, y_b, col_a, row_a, col_b, row_b, radius_a, radius_b
  input  logic [207:0]                   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // hess_xx, hess_xy, hess_yy
  output logic [143:0]                   out_tdata,
  // status
  output logic [0:0]                     out_tuser
);
  localparam int DX_W = 35;
  localparam int RT_N = hcph_pkg::ROOT_W;
  localparam int DV_N = hcph_pkg::INV_W;

  typedef struct packed {
    logic                        zero;
    logic                        nxy;
    logic [hcph_pkg::SUM_W-1:0]  sf;
    logic [hcph_pkg::S2_W-1:0]   s2;
  } sb1_t;

  typedef struct packed {
    logic                        zero;
    logic                        nxy;
    logic [32:0]                 ux2;
    logic [32:0]                 uy2;
    logic [31:0]                 uxy;
  } sb2_t;

  function automatic logic signed [DX_W-1:0] axis_d(
    input logic [31:0] pa, input logic [31:0] pb, input logic [7:0] ca,
    input logic [7:0] cb, input logic [8:0] cells, input logic [31:0] box);
    logic [31:0]            cl;
    logic signed [17:0]     span;
    logic signed [17:0]     dc;
    logic signed [DX_W-1:0] b;
    if (cells == 9'd0) cl = 32'd1;
    else if ({23'd0, cells} > 32'(MAX_CELLS)) cl = 32'(MAX_CELLS);
    else cl = {23'd0, cells};
    span = $signed(18'(cl - 32'd1));
    dc   = $signed({10'd0, cb}) - $signed({10'd0, ca});
    b    = $signed({3'b000, pb});
    if (dc == span) b = b - $signed({3'b000, box});
    else if (dc == -span) b = b + $signed({3'b000, box});
    return $signed({3'b000, pa}) - b;
  endfunction

  function automatic logic [47:0] sat48(input logic signed [68:0] v);
    if (v[68:47] == {22{v[68]}}) return v[47:0];
    else if (v[68]) return {1'b1, 47'd0};
    else return {1'b0, {47{1'b1}}};
  endfunction

  // Configuration
  logic [31:0] box_r;
  logic [8:0]  cells_x_r, cells_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r     <= hcph_pkg::BOX_RST;
      cells_x_r <= hcph_pkg::CELLS_RST;
      cells_y_r <= hcph_pkg::CELLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcph_pkg::REG_BOX:     box_r     <= cfg_wdata;
        hcph_pkg::REG_CELLS_X: cells_x_r <= cfg_wdata[8:0];
        hcph_pkg::REG_CELLS_Y: cells_y_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic skid_v_r;
  assign adv       = !skid_v_r;
  assign in_tready = adv;

  // Stage A: minimum image differences
  logic signed [DX_W-1:0] dx, dy;
  logic [32:0] a_ax_r, a_ay_r;
  logic        a_nxy_r, a_v_r;
  logic [24:0] a_s_r;

  assign dx = axis_d(in_tdata[31:0], in_tdata[95:64], in_tdata[135:128],
                     in_tdata[151:144], cells_x_r, box_r);
  assign dy = axis_d(in_tdata[63:32], in_tdata[127:96], in_tdata[143:136],
                     in_tdata[159:152], cells_y_r, box_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ax_r  <= dx[DX_W-1] ? 33'(-dx) : dx[32:0];
      a_ay_r  <= dy[DX_W-1] ? 33'(-dy) : dy[32:0];
      a_nxy_r <= dx[DX_W-1] == dy[DX_W-1];
      a_s_r   <= 25'(in_tdata[183:160]) + 25'(in_tdata[207:184]);
    end
  end

  // Stage B: squares
  logic [24:0] sf;
  logic [65:0] b_dx2_r, b_dy2_r, b_pxy_r;
  logic [24:0] b_sf_r;
  logic [49:0] b_s2_r;
  logic        b_zero_r, b_nxy_r, b_v_r;

  assign sf = (a_s_r == 25'd0) ? 25'd1 : a_s_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_dx2_r  <= a_ax_r * a_ax_r;
      b_dy2_r  <= a_ay_r * a_ay_r;
      b_pxy_r  <= a_ax_r * a_ay_r;
      b_sf_r   <= sf;
      b_s2_r   <= sf * sf;
      b_zero_r <= (a_ax_r == 33'd0) && (a_ay_r == 33'd0);
      b_nxy_r  <= a_nxy_r;
    end
  end

  // Stage C: squared distance
  logic [66:0] c_q_r;
  logic [65:0] c_dx2_r, c_dy2_r, c_pxy_r;
  sb1_t        c_sb_r;
  logic        c_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_q_r   <= 67'(b_dx2_r) + 67'(b_dy2_r);
      c_dx2_r <= b_dx2_r;
      c_dy2_r <= b_dy2_r;
      c_pxy_r <= b_pxy_r;
      c_sb_r  <= '{zero: b_zero_r, nxy: b_nxy_r, sf: b_sf_r, s2: b_s2_r};
    end
  end

  // Square root, one result bit per stage
  logic [67:0] rx_r   [RT_N];
  logic [35:0] rrem_r [RT_N];
  logic [33:0] rroot_r[RT_N];

  for (genvar k = 0; k < RT_N; k++) begin : g_sqrt
    logic [67:0] x_i;
    logic [35:0] rem_i;
    logic [33:0] root_i;
    logic [37:0] tv, tr;
    logic        ge;

    if (k == 0) begin : g_first
      assign x_i    = {1'b0, c_q_r};
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign x_i    = rx_r[k-1];
      assign rem_i  = rrem_r[k-1];
      assign root_i = rroot_r[k-1];
    end

    assign tv = {rem_i, x_i[67:66]};
    assign tr = {2'b00, root_i, 2'b01};
    assign ge = tv >= tr;

    always_ff @(posedge clk) begin
      if (adv) begin
        rx_r[k]    <= {x_i[65:0], 2'b00};
        rrem_r[k]  <= ge ? 36'(tv - tr) : tv[35:0];
        rroot_r[k] <= {root_i[32:0], ge};
      end
    end
  end

  // Squared direction cosines and their product, alongside the root
  logic [33:0] ux2_q, uy2_q, uxy_q;

  hcph_div #(.NW(98), .DW(hcph_pkg::Q_W), .QW(RT_N)) u_div_ux2 (
    .clk(clk), .en(adv), .num({c_dx2_r, 32'd0}), .den(c_q_r), .quo(ux2_q));
  hcph_div #(.NW(98), .DW(hcph_pkg::Q_W), .QW(RT_N)) u_div_uy2 (
    .clk(clk), .en(adv), .num({c_dy2_r, 32'd0}), .den(c_q_r), .quo(uy2_q));
  hcph_div #(.NW(98), .DW(hcph_pkg::Q_W), .QW(RT_N)) u_div_uxy (
    .clk(clk), .en(adv), .num({c_pxy_r, 32'd0}), .den(c_q_r), .quo(uxy_q));

  sb1_t            sb1_r [RT_N];
  logic [RT_N-1:0] v1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sb1_r[0] <= c_sb_r;
      for (int k = 1; k < RT_N; k++) sb1_r[k] <= sb1_r[k-1];
    end
  end

  // Stage D: divisor s*R
  logic [58:0] d_sr_r;
  logic [49:0] d_s2_r;
  sb2_t        d_sb_r;
  logic        d_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_sr_r <= sb1_r[RT_N-1].sf * rroot_r[RT_N-1];
      d_s2_r <= sb1_r[RT_N-1].s2;
      d_sb_r <= '{zero: sb1_r[RT_N-1].zero, nxy: sb1_r[RT_N-1].nxy,
                  ux2: ux2_q[32:0], uy2: uy2_q[32:0], uxy: uxy_q[31:0]};
    end
  end

  // Reciprocals 2^64/(s*R) and 2^64/s^2
  logic [64:0] isr_q, is2_q;

  hcph_div #(.NW(66), .DW(hcph_pkg::SR_W), .QW(DV_N)) u_div_isr (
    .clk(clk), .en(adv), .num({2'b01, 64'd0}), .den(d_sr_r), .quo(isr_q));
  hcph_div #(.NW(66), .DW(hcph_pkg::S2_W), .QW(DV_N)) u_div_is2 (
    .clk(clk), .en(adv), .num({2'b01, 64'd0}), .den(d_s2_r), .quo(is2_q));

  sb2_t            sb2_r [DV_N];
  logic [DV_N-1:0] v2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sb2_r[0] <= d_sb_r;
      for (int k = 1; k < DV_N; k++) sb2_r[k] <= sb2_r[k-1];
    end
  end

  // Stage E: split products of the 65-bit reciprocal
  sb2_t        e_in;
  logic [65:0] e_xxh_r, e_yyh_r;
  logic [64:0] e_xxl_r, e_yyl_r, e_xyh_r, e_is2_r;
  logic [63:0] e_xyl_r;
  logic        e_zero_r, e_nxy_r, e_v_r;

  assign e_in = sb2_r[DV_N-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      e_xxh_r  <= isr_q[64:32] * e_in.uy2;
      e_xxl_r  <= isr_q[31:0] * e_in.uy2;
      e_yyh_r  <= isr_q[64:32] * e_in.ux2;
      e_yyl_r  <= isr_q[31:0] * e_in.ux2;
      e_xyh_r  <= isr_q[64:32] * e_in.uxy;
      e_xyl_r  <= isr_q[31:0] * e_in.uxy;
      e_is2_r  <= is2_q;
      e_zero_r <= e_in.zero;
      e_nxy_r  <= e_in.nxy;
    end
  end

  // Stage F: recombine, drop 32 fraction bits
  logic [66:0] f_xx_r, f_yy_r, f_xy_r;
  logic [64:0] f_is2_r;
  logic        f_zero_r, f_nxy_r, f_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_xx_r   <= 67'(e_xxh_r) + 67'(e_xxl_r[64:32]);
      f_yy_r   <= 67'(e_yyh_r) + 67'(e_yyl_r[64:32]);
      f_xy_r   <= 67'(e_xyh_r) + 67'(e_xyl_r[63:32]);
      f_is2_r  <= e_is2_r;
      f_zero_r <= e_zero_r;
      f_nxy_r  <= e_nxy_r;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      v1_r  <= '0;
      d_v_r <= 1'b0;
      v2_r  <= '0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_tvalid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      v1_r  <= {v1_r[RT_N-2:0], c_v_r};
      d_v_r <= v1_r[RT_N-1];
      v2_r  <= {v2_r[DV_N-2:0], d_v_r};
      e_v_r <= v2_r[DV_N-1];
      f_v_r <= e_v_r;
    end
  end

  // Saturate and pack
  logic signed [68:0] g_xx, g_yy, g_xy, g_mag;
  logic [143:0]       g_data;
  logic               push, out_take;

  assign g_xx  = $signed({2'b00, f_xx_r}) - $signed({4'b0000, f_is2_r});
  assign g_yy  = $signed({2'b00, f_yy_r}) - $signed({4'b0000, f_is2_r});
  assign g_mag = $signed({2'b00, f_xy_r});
  assign g_xy  = f_nxy_r ? -g_mag : g_mag;
  assign g_data = f_zero_r ? 144'd0 : {sat48(g_yy), sat48(g_xy), sat48(g_xx)};

  assign push     = adv && f_v_r;
  assign out_take = out_tvalid && out_tready;

  // Output register with one skid entry
  logic [143:0] out_d_r, skid_d_r;
  logic         out_u_r, skid_u_r, out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || out_take) out_v_r <= 1'b1;
      else skid_v_r <= 1'b1;
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_d_r <= skid_d_r;
        out_u_r <= skid_u_r;
      end
    end else if (push) begin
      if (!out_v_r || out_take) begin
        out_d_r <= g_data;
        out_u_r <= f_zero_r;
      end else begin
        skid_d_r <= g_data;
        skid_u_r <= f_zero_r;
      end
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_d_r;
  assign out_tuser[0] = out_u_r;

  `HCPH_ASSERT_NOW(a_skid_behind_out, skid_v_r, out_tvalid)
  `HCPH_ASSERT_NEXT(a_skid_drains, skid_v_r && out_tready, !skid_v_r)
  `HCPH_ASSERT_NOW(a_coincident_zero, out_tvalid && out_tuser[0], out_tdata == 144'd0)
endmodule

// File: test/harmonic_contact_pair_hessian_tb.sv
// Testbench for the contact pair Hessian: random and directed disk pairs,
// predicted in a scoreboard class and checked result by result.
// Depends on hcph_pkg and harmonic_contact_pair_hessian.
module harmonic_contact_pair_hessian_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0] radius_b;
    logic [23:0] radius_a;
    logic [7:0]  row_b;
    logic [7:0]  col_b;
    logic [7:0]  row_a;
    logic [7:0]  col_a;
    logic [31:0] y_b;
    logic [31:0] x_b;
    logic [31:0] y_a;
    logic [31:0] x_a;
  } pair_t;

  typedef struct packed {
    logic        status;
    logic [47:0] yy;
    logic [47:0] xy;
    logic [47:0] xx;
  } hess_t;

  class hessian_board;
    logic [31:0] box;
    logic [8:0]  ncx, ncy;
    hess_t       pending[$];
    int          errors;

    function new();
      box = hcph_pkg::BOX_RST; ncx = hcph_pkg::CELLS_RST; ncy = hcph_pkg::CELLS_RST;
      errors = 0;
    endfunction

    function automatic logic signed [34:0] axis(logic [31:0] pa, logic [31:0] pb,
        logic [7:0] ca, logic [7:0] cb, logic [8:0] cells);
      int span, dc;
      logic signed [34:0] b;
      span = (cells < 1) ? 0 : (cells > 256 ? 255 : int'(cells) - 1);
      dc = int'(cb) - int'(ca);
      b = $signed({3'b0, pb});
      if (dc == span) b = b - $signed({3'b0, box});
      else if (dc == -span) b = b + $signed({3'b0, box});
      return $signed({3'b0, pa}) - b;
    endfunction

    function automatic logic [47:0] sat48(logic signed [135:0] v);
      if (v > 136'sh7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
      if (v < -136'sh8000_0000_0000) return 48'h8000_0000_0000;
      return v[47:0];
    endfunction

    function void note_pair(pair_t p);
      logic signed [34:0] dx, dy;
      logic [33:0] ax, ay, rr;
      logic [135:0] q, s, isr, is2, ux2, uy2, uxy, mag, two64, t;
      hess_t h;
      dx = axis(p.x_a, p.x_b, p.col_a, p.col_b, ncx);
      dy = axis(p.y_a, p.y_b, p.row_a, p.row_b, ncy);
      ax = dx < 0 ? 34'(-dx) : 34'(dx);
      ay = dy < 0 ? 34'(-dy) : 34'(dy);
      q = ax * ax + ay * ay;
      h = '0;
      if (q == 0) begin
        h.status = 1'b1;
      end else begin
        s = p.radius_a + p.radius_b;
        if (s == 0) s = 1;
        rr = 0;
        for (int i = 33; i >= 0; i--) begin
          t = rr | (34'd1 << i);
          if (t * t <= q) rr = t[33:0];
        end
        two64 = 136'd1 << 64;
        isr = two64 / (s * rr);
        is2 = two64 / (s * s);
        ux2 = ((ax * ax) << 32) / q;
        uy2 = ((ay * ay) << 32) / q;
        uxy = ((ax * ay) << 32) / q;
        h.xx = sat48($signed((isr * uy2[63:0]) >> 32) - $signed(is2));
        h.yy = sat48($signed((isr * ux2[63:0]) >> 32) - $signed(is2));
        mag = (isr * uxy[63:0]) >> 32;
        h.xy = ((dx < 0) == (dy < 0)) ? sat48(-$signed(mag)) : sat48($signed(mag));
      end
      pending.push_back(h);
    endfunction

    function void check_result(hess_t got);
      hess_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.xx !== e.xx) begin
        $display("%0t hess_xx expected %h actual %h", $time, e.xx, got.xx); errors++;
      end
      if (got.xy !== e.xy) begin
        $display("%0t hess_xy expected %h actual %h", $time, e.xy, got.xy); errors++;
      end
      if (got.yy !== e.yy) begin
        $display("%0t hess_yy expected %h actual %h", $time, e.yy, got.yy); errors++;
      end
      if (got.status !== e.status) begin
        $display("%0t status expected %b actual %b", $time, e.status, got.status); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, cfg_we, in_tvalid, in_tready, out_tvalid, out_tready;
  logic [hcph_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hcph_pkg::CFG_W-1:0] cfg_wdata;
  logic [207:0] in_tdata;
  logic [143:0] out_tdata;
  logic [0:0] out_tuser;
  hessian_board board;
  bit calm;

  harmonic_contact_pair_hessian DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  // sink: random stall bursts until the calm phase
  initial begin
    int gap;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        gap = $urandom_range(1, 9);
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      board.check_result({out_tuser[0], out_tdata});

  task automatic write_reg(logic [hcph_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      hcph_pkg::REG_BOX:     board.box = v;
      hcph_pkg::REG_CELLS_X: board.ncx = v[8:0];
      hcph_pkg::REG_CELLS_Y: board.ncy = v[8:0];
      default: ;
    endcase
  endtask

  task automatic send_pair(pair_t p);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_pair(p);
  endtask

  task automatic drain();
    int n;
    in_tvalid <= 0;
    n = 0;
    while (board.pending.size() != 0 && n < 200000) begin
      @(posedge clk); n++;
    end
    repeat (120) @(posedge clk);
  endtask

  function automatic pair_t rand_pair(logic [8:0] cx, logic [8:0] cy);
    pair_t p;
    int span;
    p.x_a = $urandom; p.y_a = $urandom; p.x_b = $urandom; p.y_b = $urandom;
    case ($urandom_range(0, 3))
      0: begin
        p.x_b = p.x_a + $urandom_range(0, 300000) - 150000;
        p.y_b = p.y_a + $urandom_range(0, 300000) - 150000;
      end
      1: begin p.x_b = p.x_a; p.y_b = p.y_a + $urandom_range(0, 3); end
      default: ;
    endcase
    p.col_a = $urandom; p.row_a = $urandom; p.col_b = $urandom; p.row_b = $urandom;
    if ($urandom_range(0, 1)) begin
      span = (cx > 256 ? 256 : (cx == 0 ? 1 : cx)) - 1;
      p.col_a = $urandom_range(0, 255 - span); p.col_b = p.col_a + span;
      if ($urandom_range(0, 1)) {p.col_a, p.col_b} = {p.col_b, p.col_a};
      span = (cy > 256 ? 256 : (cy == 0 ? 1 : cy)) - 1;
      p.row_a = $urandom_range(0, 255 - span); p.row_b = p.row_a + span;
      if ($urandom_range(0, 1)) {p.row_a, p.row_b} = {p.row_b, p.row_a};
    end
    p.radius_a = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(1, 200000);
    p.radius_b = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(1, 200000);
    return p;
  endfunction

  initial begin
    pair_t p;
    logic [31:0] boxes[5];
    logic [8:0] cells[5];
    boxes = '{32'd1, 32'hFFFF_FFFF, 32'd1048576, 32'h0040_0000, 32'd0};
    cells = '{9'd1, 9'd256, 9'd16, 9'd511, 9'd0};
    board = new();
    calm = 0;
    rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_tvalid = 0; in_tdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: coincident, extremes, wrap in both directions, zero radius sum
    p = '0; send_pair(p);
    p = '1; send_pair(p);
    p = '0; p.x_a = 32'hFFFF_FFFF; p.radius_a = 24'hFF_FFFF; p.radius_b = 24'hFF_FFFF;
    send_pair(p);
    p = '0; p.y_b = 32'hFFFF_FFFF; p.radius_a = 1; send_pair(p);
    p = '0; p.x_a = 32'h0001_0000; p.y_a = 32'h0001_0000; p.col_b = 15; p.row_b = 15;
    p.radius_a = 24'h00_8000; p.radius_b = 24'h00_8000; send_pair(p);
    p.col_a = 15; p.col_b = 0; p.row_a = 15; p.row_b = 0; send_pair(p);
    p = '0; p.x_a = 1; p.y_b = 1; p.radius_a = 1; p.radius_b = 1; send_pair(p);
    p = '0; p.x_a = 32'h0000_0100; p.y_a = 32'h0000_0100; p.radius_a = 1; send_pair(p);
    p = '0; p.x_a = 32'h0000_0100; p.y_b = 32'h0000_0100; p.radius_b = 1; send_pair(p);
    p = '0; p.x_a = 32'h0001_0000; p.y_b = 32'h0000_8000; send_pair(p);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(hcph_pkg::REG_BOX, boxes[ph]);
      write_reg(hcph_pkg::REG_CELLS_X, {23'd0, cells[ph]});
      write_reg(hcph_pkg::REG_CELLS_Y, {23'd0, cells[4 - ph]});
      if (ph == 4) calm = 1;
      for (int i = 0; i < 200; i++) begin
        p = rand_pair(board.ncx, board.ncy);
        send_pair(p);
      end
      // hold off the sender until every result is back
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
